// ===== rtl/core/crm_pkg.sv =====
// crm_pkg: shared types and codes for the chunk range mapper
// holds request op codes, result kinds, extent record and sequencer states
// no dependencies
package crm_pkg;

  // request op codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_MAP    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_SEGMENT = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  localparam int unsigned EXT_W   = 32;
  localparam int unsigned RANGE_W = 48;

  // one stored extent
  typedef struct packed {
    logic [EXT_W-1:0] blk;
    logic [EXT_W-1:0] offset;
    logic [EXT_W-1:0] length;
  } ext_t;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SEEK  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

// ===== rtl/core/chunk_range_mapper.sv =====
// chunk_range_mapper: extent table with logical range mapping
// depends on crm_pkg (types, op codes, result kinds)
// one shared subtract/compare unit walks the extent memory under a small sequencer
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  request  | start, busy, in_op, in_extent_*, in_range_* | taken when start & !busy
//  result   | out_valid, out_kind, out_seg_*, out_last   | one-cycle strobe, no stall
//
// clear and append are taken while idle and never raise busy. a map request
// holds busy for a range check, a seek step for each extent ahead of the range
// start, a step to trim the first overlapping extent, then an emit step for each
// extent from there up to the last segment, bounded by the single-port walk of
// the extent memory. results leave through a register, in the cycle after they
// are formed; the receiver cannot stall them. rst_n (synchronous) empties the
// table; stored extents are kept.
module chunk_range_mapper #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [crm_pkg::EXT_W-1:0]     in_extent_block,
  input  logic [crm_pkg::EXT_W-1:0]     in_extent_offset,
  input  logic [crm_pkg::EXT_W-1:0]     in_extent_length,
  input  logic [crm_pkg::RANGE_W-1:0]   in_range_start,
  input  logic [crm_pkg::RANGE_W-1:0]   in_range_length,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic [crm_pkg::EXT_W-1:0]     out_seg_block,
  output logic [crm_pkg::EXT_W:0]       out_seg_offset,
  output logic [crm_pkg::EXT_W-1:0]     out_seg_length,
  output logic                          out_last
);

  localparam int unsigned EW     = crm_pkg::EXT_W;
  localparam int unsigned RW     = crm_pkg::RANGE_W;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TOT_W  = EW + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  // extent memory and its registered read port
  crm_pkg::ext_t mem [TABLE_DEPTH];
  crm_pkg::ext_t rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  // control state
  crm_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  // walk state
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [RW-1:0]    skip_r, skip_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [EW-1:0]    avail_r, avail_nxt;
  logic [EW-1:0]    rel_r, rel_nxt;
  logic             first_r, first_nxt;

  // result register
  logic             ov_r, ov_nxt;
  logic [1:0]       okind_r, okind_nxt;
  logic [EW-1:0]    oblk_r, oblk_nxt;
  logic [EW:0]      ooff_r, ooff_nxt;
  logic [EW-1:0]    olen_r, olen_nxt;
  logic             olast_r, olast_nxt;

  // shared arithmetic
  logic [RW:0]      tot_ext;
  logic [RW:0]      alu_a;
  logic [RW:0]      alu_b;
  logic [RW:0]      alu_diff;
  logic             diff_nonpos;
  logic             range_err;
  logic [EW-1:0]    cur_avail;
  logic [EW-1:0]    cur_rel;
  logic [IDX_W-1:0] idx_inc;

  crm_pkg::op_t req_op;

  assign req_op    = crm_pkg::op_t'(in_op);
  assign busy      = (state_r != crm_pkg::ST_IDLE);
  assign tot_ext   = (RW + 1)'(total_r);
  assign cur_avail = first_r ? avail_r : rd_q.length;
  assign cur_rel   = first_r ? rel_r : '0;
  assign idx_inc   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  // one subtractor: total minus start in check, start minus extent in seek,
  // remaining minus available in emit
  assign alu_a = (state_r == crm_pkg::ST_CHECK) ? tot_ext :
                 (state_r == crm_pkg::ST_SEEK)  ? {1'b0, skip_r} : {1'b0, rem_r};
  assign alu_b = (state_r == crm_pkg::ST_CHECK) ? {1'b0, skip_r} :
                 (state_r == crm_pkg::ST_SEEK)  ? {(RW + 1 - EW)'(0), rd_q.length} :
                                                  {(RW + 1 - EW)'(0), cur_avail};
  assign alu_diff    = alu_a - alu_b;
  assign diff_nonpos = alu_diff[RW] || (alu_diff == '0);
  // range runs past the total when length exceeds what is left after the start
  assign range_err   = (rem_r != '0) && (alu_diff[RW] || ({1'b0, rem_r} > alu_diff));

  // extent memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{blk: in_extent_block, offset: in_extent_offset,
                        length: in_extent_length};
    end
    rd_q <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    skip_nxt  = skip_r;
    rem_nxt   = rem_r;
    avail_nxt = avail_r;
    rel_nxt   = rel_r;
    first_nxt = first_r;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = count_r[IDX_W-1:0];
    ov_nxt    = 1'b0;
    okind_nxt = okind_r;
    oblk_nxt  = oblk_r;
    ooff_nxt  = ooff_r;
    olen_nxt  = olen_r;
    olast_nxt = olast_r;

    unique case (state_r)
      crm_pkg::ST_IDLE: begin
        if (start) begin
          unique case (req_op)
            crm_pkg::OP_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            crm_pkg::OP_APPEND: begin
              if (count_r < FULL_CNT) begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                total_nxt = total_r + TOT_W'(in_extent_length);
              end
            end
            crm_pkg::OP_MAP: begin
              skip_nxt  = in_range_start;
              rem_nxt   = in_range_length;
              state_nxt = crm_pkg::ST_CHECK;
            end
            default: begin
            end
          endcase
        end
      end

      // range check against the total length, prefetch entry zero
      crm_pkg::ST_CHECK: begin
        rd_addr   = '0;
        idx_nxt   = '0;
        first_nxt = 1'b1;
        if (range_err) begin
          ov_nxt    = 1'b1;
          okind_nxt = crm_pkg::KIND_ERROR;
          oblk_nxt  = '0;
          ooff_nxt  = '0;
          olen_nxt  = '0;
          olast_nxt = 1'b1;
          state_nxt = crm_pkg::ST_IDLE;
        end else if (diff_nonpos) begin
          ov_nxt    = 1'b1;
          okind_nxt = crm_pkg::KIND_EMPTY;
          oblk_nxt  = '0;
          ooff_nxt  = '0;
          olen_nxt  = '0;
          olast_nxt = 1'b1;
          state_nxt = crm_pkg::ST_IDLE;
        end else begin
          state_nxt = crm_pkg::ST_SEEK;
        end
      end

      // skip whole extents that lie before the range start
      crm_pkg::ST_SEEK: begin
        if (alu_diff[RW]) begin
          // start falls in this extent: keep it on the read port and trim
          avail_nxt = EW'(-alu_diff);
          rel_nxt   = skip_r[EW-1:0];
          rd_addr   = idx_r;
          state_nxt = crm_pkg::ST_EMIT;
        end else begin
          skip_nxt = alu_diff[RW-1:0];
          idx_nxt  = idx_inc;
          rd_addr  = idx_inc;
        end
      end

      // one segment per overlapping extent
      crm_pkg::ST_EMIT: begin
        if (first_r || (rd_q.length != '0)) begin
          ov_nxt    = 1'b1;
          okind_nxt = crm_pkg::KIND_SEGMENT;
          oblk_nxt  = rd_q.blk;
          ooff_nxt  = {1'b0, rd_q.offset} + {1'b0, cur_rel};
          olen_nxt  = diff_nonpos ? rem_r[EW-1:0] : cur_avail;
          olast_nxt = diff_nonpos;
        end
        first_nxt = 1'b0;
        if (diff_nonpos) begin
          rem_nxt   = '0;
          state_nxt = crm_pkg::ST_IDLE;
        end else begin
          rem_nxt = alu_diff[RW-1:0];
          idx_nxt = idx_inc;
          rd_addr = idx_inc;
        end
      end

      default: begin
        state_nxt = crm_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crm_pkg::ST_IDLE;
      count_r <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    skip_r  <= skip_nxt;
    rem_r   <= rem_nxt;
    avail_r <= avail_nxt;
    rel_r   <= rel_nxt;
    first_r <= first_nxt;
    okind_r <= okind_nxt;
    oblk_r  <= oblk_nxt;
    ooff_r  <= ooff_nxt;
    olen_r  <= olen_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_kind       = okind_r;
  assign out_seg_block  = oblk_r;
  assign out_seg_offset = ooff_r;
  assign out_seg_length = olen_r;
  assign out_last       = olast_r;

endmodule

// ===== tb/chunk_range_mapper_tb.sv =====
// chunk_range_mapper_tb: self-checking bench for the extent table range mapper
// depends on crm_pkg and chunk_range_mapper; a scoreboard class predicts the segments
// directed corner requests first, then random append/map bursts, table fills and noise
module chunk_range_mapper_tb;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned N_ITEMS   = 460;
  localparam logic [47:0] RANGE_MAX = 48'hFFFF_FFFF_FFFF;

  // one expected result of a map request
  typedef struct {
    crm_pkg::kind_t kind;
    logic [31:0]    blk;
    logic [32:0]    offset;
    logic [31:0]    length;
    logic           last;
  } seg_rec_t;

  // extent table copy, running total and the segments still owed by the block
  class extent_map_scoreboard;
    logic [31:0] blk_tab [DEPTH];
    logic [31:0] off_tab [DEPTH];
    logic [31:0] len_tab [DEPTH];
    int unsigned n_extents;
    logic [63:0] total_len;
    seg_rec_t    expected_segs[$];
    int unsigned mismatches;

    function new();
      n_extents   = 0;
      total_len   = '0;
      mismatches  = 0;
    endfunction

    // queue one owed result behind the others
    function void owe_segment(seg_rec_t s);
      expected_segs = {expected_segs, s};
    endfunction

    // update the table or work out the segments for one accepted request
    function void note_request(crm_pkg::op_t op, logic [31:0] blk, logic [31:0] off,
                               logic [31:0] len, logic [47:0] rs, logic [47:0] rl);
      logic [63:0] from, left, pos, elen, rel, avail, take;
      seg_rec_t    seg;
      case (op)
        crm_pkg::OP_CLEAR: begin
          n_extents = 0;
          total_len = '0;
        end
        crm_pkg::OP_APPEND: begin
          // appends to a full table are dropped
          if (n_extents < DEPTH) begin
            blk_tab[n_extents] = blk;
            off_tab[n_extents] = off;
            len_tab[n_extents] = len;
            n_extents++;
            total_len += {32'd0, len};
          end
        end
        crm_pkg::OP_MAP: begin
          from = {16'd0, rs};
          left = {16'd0, rl};
          seg  = '{crm_pkg::KIND_SEGMENT, '0, '0, '0, 1'b1};
          if (left != 0 && from + left > total_len) begin
            seg.kind = crm_pkg::KIND_ERROR;
            owe_segment(seg);
          end else if (from >= total_len) begin
            // zero-length range past every extent
            seg.kind = crm_pkg::KIND_EMPTY;
            owe_segment(seg);
          end else begin
            // walk extents in order, one segment per overlapped extent
            pos = '0;
            for (int unsigned i = 0; i < n_extents; i++) begin
              elen = {32'd0, len_tab[i]};
              if (pos + elen > from) begin
                rel   = from - pos;
                avail = elen - rel;
                take  = (left < avail) ? left : avail;
                left -= take;
                seg.blk    = blk_tab[i];
                seg.offset = {1'b0, off_tab[i]} + rel[32:0];
                seg.length = take[31:0];
                seg.last   = (left == 0);
                owe_segment(seg);
                if (left == 0) break;
                from += take;
              end
              pos += elen;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one result strobe with the oldest owed segment
    function void check_result(logic [1:0] kind, logic [31:0] blk, logic [32:0] off,
                               logic [31:0] len, logic last);
      seg_rec_t want;
      if (expected_segs.size() == 0) begin
        $error("result with nothing expected: kind %0d block %0h", kind, blk);
        mismatches++;
        return;
      end
      want = expected_segs.pop_front();
      compare_field("kind", 64'(want.kind), 64'(kind));
      compare_field("seg_block", 64'(want.blk), 64'(blk));
      compare_field("seg_offset", 64'(want.offset), 64'(off));
      compare_field("seg_length", 64'(want.length), 64'(len));
      compare_field("last", 64'(want.last), 64'(last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [31:0] in_extent_block;
  logic [31:0] in_extent_offset;
  logic [31:0] in_extent_length;
  logic [47:0] in_range_start;
  logic [47:0] in_range_length;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_seg_block;
  logic [32:0] out_seg_offset;
  logic [31:0] out_seg_length;
  logic        out_last;

  extent_map_scoreboard ledger = new();
  int unsigned          n_sent;
  bit                   gaps_off;

  chunk_range_mapper #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_extent_block  (in_extent_block),
    .in_extent_offset (in_extent_offset),
    .in_extent_length (in_extent_length),
    .in_range_start   (in_range_start),
    .in_range_length  (in_range_length),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_seg_block    (out_seg_block),
    .out_seg_offset   (out_seg_offset),
    .out_seg_length   (out_seg_length),
    .out_last         (out_last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor, the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      ledger.check_result(out_kind, out_seg_block, out_seg_offset, out_seg_length, out_last);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [63:0] pick_upto(logic [63:0] max);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r % (max + 1);
  endfunction

  function automatic logic [31:0] pick_extent_length();
    case ($urandom_range(9))
      0:       return 32'd0;
      1, 2, 3,
      4, 5:    return 32'($urandom_range(1, 64));
      6, 7:    return 32'($urandom_range(1, 4096));
      8:       return $urandom;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // present one request, with a random idle gap first unless gaps_off is set, and hold it until taken
  task automatic send_request(crm_pkg::op_t op, logic [31:0] blk, logic [31:0] off,
                              logic [31:0] len, logic [47:0] rs, logic [47:0] rl);
    while (!gaps_off && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_op            <= op;
    in_extent_block  <= blk;
    in_extent_offset <= off;
    in_extent_length <= len;
    in_range_start   <= rs;
    in_range_length  <= rl;
    do @(posedge clk); while (busy);
    ledger.note_request(op, blk, off, len, rs, rl);
    if (op != crm_pkg::OP_NONE) n_sent++;
  endtask

  task automatic append_extent(logic [31:0] blk, logic [31:0] off, logic [31:0] len);
    send_request(crm_pkg::OP_APPEND, blk, off, len, rand48(), rand48());
  endtask

  task automatic map_request(logic [47:0] rs, logic [47:0] rl);
    send_request(crm_pkg::OP_MAP, $urandom, $urandom, $urandom, rs, rl);
  endtask

  // map a range shaped against the current total length
  task automatic map_within();
    logic [63:0] tot, rs, rl;
    tot = ledger.total_len;
    if (tot == 0) begin
      map_request('0, '0);
      return;
    end
    case ($urandom_range(5))
      0: begin rs = '0;                 rl = tot;              end
      1: begin rs = pick_upto(tot - 1); rl = '0;               end
      2: begin rs = pick_upto(tot - 1); rl = tot - rs;         end
      3: begin rs = pick_upto(tot);     rl = tot - rs + 1;     end
      default: begin
        rs = pick_upto(tot - 1);
        rl = pick_upto(tot - rs);
      end
    endcase
    map_request(rs[47:0], rl[47:0]);
  endtask

  // stimulus
  initial begin
    logic [47:0] tot;
    int unsigned pick;
    n_sent           = 0;
    gaps_off         = 1'b0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_op            <= crm_pkg::OP_NONE;
    in_extent_block  <= '0;
    in_extent_offset <= '0;
    in_extent_length <= '0;
    in_range_start   <= '0;
    in_range_length  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, unused op, field extremes and range corner cases
    map_request('0, '0);
    map_request('0, 48'd1);
    send_request(crm_pkg::OP_NONE, '1, '1, '1, RANGE_MAX, RANGE_MAX);
    append_extent(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    append_extent(32'd0, 32'd0, 32'd0);
    append_extent(32'h1234_5678, 32'h0000_0100, 32'h0000_1000);
    append_extent(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd10);
    tot = ledger.total_len[47:0];
    map_request('0, tot);
    map_request(48'hFFFF_FFFE, 48'd4);
    map_request(48'hFFFF_FFFF, '0);
    map_request(tot - 1, 48'd1);
    map_request(tot - 5, '0);
    map_request(48'd5, '0);
    map_request(tot, '0);
    map_request(tot, 48'd1);
    map_request(RANGE_MAX, RANGE_MAX);
    map_request(RANGE_MAX, '0);
    map_request('0, RANGE_MAX);
    send_request(crm_pkg::OP_CLEAR, '1, '1, '1, RANGE_MAX, RANGE_MAX);
    map_request('0, '0);
    append_extent(32'd1, 32'd2, 32'd3);
    map_request(48'd1, 48'd2);

    // random bursts: mostly well-formed append/map runs, some table fills and noise
    while (n_sent < N_ITEMS) begin
      gaps_off = (n_sent >= 180 && n_sent < 260);
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(9) < 3) send_request(crm_pkg::OP_CLEAR, $urandom, $urandom,
                                                $urandom, rand48(), rand48());
        repeat ($urandom_range(1, 8)) append_extent($urandom, $urandom, pick_extent_length());
        repeat ($urandom_range(2, 6)) map_within();
      end else if (pick < 74 && n_sent < N_ITEMS - 80) begin
        // fill past capacity with short extents so maps span the whole table
        send_request(crm_pkg::OP_CLEAR, $urandom, $urandom, $urandom, rand48(), rand48());
        repeat (DEPTH + $urandom_range(1, 3))
          append_extent($urandom, $urandom, 32'($urandom_range(0, 16)));
        map_request('0, ledger.total_len[47:0]);
        repeat (3) map_within();
      end else begin
        repeat ($urandom_range(3, 6)) begin
          send_request(crm_pkg::op_t'($urandom_range(3)), $urandom, $urandom, $urandom,
                       rand48(), ($urandom_range(3) == 0) ? 48'd0 : rand48());
        end
      end
    end

    // drain, then allow for the longest map walk
    start <= 1'b0;
    while (ledger.expected_segs.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.expected_segs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
